### rtl/lwr_pkg.sv
package lwr_pkg;

   localparam int MODULUS = 3329;
   localparam int HALF_Q  = MODULUS / 2;

   localparam int COEF_W  = 12;
   localparam int PB_W    = 4;
   localparam int MB_W    = 3;
   localparam int PB_MIN  = 1;
   localparam int PB_MAX  = 11;
   localparam int MB_MIN  = 1;
   localparam int MB_MAX  = 4;

   localparam int Y_W       = $clog2(MODULUS * (2 ** PB_MAX));
   localparam int QUO_W     = $clog2((2 ** PB_MAX) + 2);
   localparam int RCP_SHIFT = Y_W + 1;
   localparam int RCP       = (2 ** RCP_SHIFT) / MODULUS;
   localparam int RCP_W     = $clog2(RCP + 1);
   localparam int PROD_W    = Y_W + RCP_W;
   localparam int DQ_W      = 2 * COEF_W;

   localparam logic [COEF_W-1:0] Q_C      = COEF_W'(MODULUS);
   localparam logic [COEF_W-1:0] HALF_Q_C = COEF_W'(HALF_Q);
   localparam logic [PB_W-1:0]   QB_RESET = PB_W'(10);
   localparam logic [MB_W-1:0]   MB_RESET = MB_W'(1);
   localparam logic [PB_W-1:0]   QB_LO    = PB_W'(PB_MIN);
   localparam logic [PB_W-1:0]   QB_HI    = PB_W'(PB_MAX);
   localparam logic [MB_W-1:0]   MB_LO    = MB_W'(MB_MIN);
   localparam logic [MB_W-1:0]   MB_HI    = MB_W'(MB_MAX);

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_QUANT,
      OP_DEQUANT,
      OP_ENCODE,
      OP_DECODE
   } op_type;

   typedef enum logic {
      CSR_QUANT_BITS,
      CSR_MSG_BITS
   } csr_type;

   typedef struct packed {
      op_type            op;
      logic              err;
      logic [COEF_W-1:0] opa;
      logic [COEF_W-1:0] early;
      logic              neg;
      logic [PB_W-1:0]   pbits;
      logic [MB_W-1:0]   mbits;
   } pipe_type;

   typedef struct packed {
      logic load_c;
      logic load_d;
   } div_ctrl_type;

endpackage

### rtl/lwr_divq.sv
module lwr_divq (
   input  logic                        clock,
   input  lwr_pkg::div_ctrl_type       ctrl,
   input  logic [lwr_pkg::Y_W-1:0]     y,
   output logic [lwr_pkg::QUO_W-1:0]   quo
);

   logic [lwr_pkg::QUO_W-1:0]  est_c_ff;
   logic [lwr_pkg::QUO_W-1:0]  est_c_in;
   logic [lwr_pkg::Y_W-1:0]    y_c_ff;
   logic [lwr_pkg::QUO_W-1:0]  est_d_ff;
   logic [lwr_pkg::Y_W-1:0]    y_d_ff;
   logic [lwr_pkg::Y_W-1:0]    prod_d_ff;
   logic [lwr_pkg::Y_W-1:0]    prod_d_in;
   logic [lwr_pkg::PROD_W-1:0] rcp_prod;
   logic [lwr_pkg::Y_W-1:0]    rem;

   // estimate is exact or one low
   assign rcp_prod  = lwr_pkg::PROD_W'(y) * lwr_pkg::PROD_W'(lwr_pkg::RCP);
   assign est_c_in  = lwr_pkg::QUO_W'(rcp_prod >> lwr_pkg::RCP_SHIFT);
   assign prod_d_in = lwr_pkg::Y_W'(lwr_pkg::Y_W'(est_c_ff) * lwr_pkg::Y_W'(lwr_pkg::MODULUS));

   always_ff @(posedge clock) begin
      if (ctrl.load_c) begin
         est_c_ff <= est_c_in;
         y_c_ff   <= y;
      end
      if (ctrl.load_d) begin
         est_d_ff  <= est_c_ff;
         y_d_ff    <= y_c_ff;
         prod_d_ff <= prod_d_in;
      end
   end

   assign rem = y_d_ff - prod_d_ff;
   assign quo = (rem >= lwr_pkg::Y_W'(lwr_pkg::MODULUS)) ? est_d_ff + lwr_pkg::QUO_W'(1)
                                                          : est_d_ff;

endmodule

### rtl/lwr_coefficient_unit.sv
// An accepted item passes through registered stages A to E to its result on the rsp side.
// Throughput: one item per cycle while rsp_tready does not stall it; five register stages, the divide by Q
// is a reciprocal multiply and a one-step correction spread over three stages.
// Reset (synchronous, active high) empties the pipeline and sets
// quant_bits to 10 and msg_bits to 1.
module lwr_coefficient_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operand_a [11:0], operand_b [23:12]
   input  logic [2:0]  req_tuser,   // op [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result [11:0], domain_error [12], zero [15:13]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int CW = lwr_pkg::COEF_W;

   logic [lwr_pkg::PB_W-1:0] quant_bits_ff;
   logic [lwr_pkg::MB_W-1:0] msg_bits_ff;

   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

   lwr_pkg::pipe_type pa_ff, pa_in;
   lwr_pkg::pipe_type pb_ff, pb_in;
   lwr_pkg::pipe_type pc_ff, pc_in;
   lwr_pkg::pipe_type pd_ff;

   logic [lwr_pkg::Y_W-1:0]   y_b_ff, y_b_in;
   logic [lwr_pkg::QUO_W-1:0] quo;
   lwr_pkg::div_ctrl_type     div_ctrl;

   logic [CW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_err_ff;

   // stage A inputs
   lwr_pkg::op_type          op_i;
   logic [CW-1:0]            a_i, b_i, mag_i;
   logic [CW:0]              sum_i, diff_i;
   logic [CW-1:0]            sum_mod_i, diff_mod_i;
   logic                     a_ge_q, b_ge_q, neg_i;
   logic [lwr_pkg::PB_W-1:0] pbits_i;
   logic [lwr_pkg::MB_W-1:0] mbits_i;

   // stage B
   logic [lwr_pkg::DQ_W-1:0] dq_prod;
   logic [CW-1:0]            deq_b, enc_b;

   // stage E
   logic [CW-1:0] pmask, mmask, t_e;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_bits_ff <= lwr_pkg::QB_RESET;
         msg_bits_ff   <= lwr_pkg::MB_RESET;
      end else if (csr_we) begin
         case (lwr_pkg::csr_type'(csr_index))
            lwr_pkg::CSR_QUANT_BITS: quant_bits_ff <= csr_wdata;
            lwr_pkg::CSR_MSG_BITS:   msg_bits_ff   <= csr_wdata[lwr_pkg::MB_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign rdy_e      = !vld_e_ff || rsp_tready;
   assign rdy_d      = !vld_d_ff || rdy_e;
   assign rdy_c      = !vld_c_ff || rdy_d;
   assign rdy_b      = !vld_b_ff || rdy_c;
   assign rdy_a      = !vld_a_ff || rdy_b;
   assign req_tready = rdy_a;
   assign rsp_tvalid = vld_e_ff;
   assign rsp_tdata  = {3'b000, rsp_err_ff, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
      end else begin
         if (rdy_a) vld_a_ff <= req_tvalid;
         if (rdy_b) vld_b_ff <= vld_a_ff;
         if (rdy_c) vld_c_ff <= vld_b_ff;
         if (rdy_d) vld_d_ff <= vld_c_ff;
         if (rdy_e) vld_e_ff <= vld_d_ff;
      end
   end

   // stage A: range checks, add and subtract mod Q, centering
   always_comb begin
      op_i   = lwr_pkg::op_type'(req_tuser);
      a_i    = req_tdata[11:0];
      b_i    = req_tdata[23:12];
      a_ge_q = a_i >= lwr_pkg::Q_C;
      b_ge_q = b_i >= lwr_pkg::Q_C;

      if (quant_bits_ff < lwr_pkg::QB_LO)      pbits_i = lwr_pkg::QB_LO;
      else if (quant_bits_ff > lwr_pkg::QB_HI) pbits_i = lwr_pkg::QB_HI;
      else                                     pbits_i = quant_bits_ff;
      if (msg_bits_ff < lwr_pkg::MB_LO)        mbits_i = lwr_pkg::MB_LO;
      else if (msg_bits_ff > lwr_pkg::MB_HI)   mbits_i = lwr_pkg::MB_HI;
      else                                     mbits_i = msg_bits_ff;

      sum_i      = {1'b0, a_i} + {1'b0, b_i};
      sum_mod_i  = (sum_i >= {1'b0, lwr_pkg::Q_C}) ? CW'(sum_i - {1'b0, lwr_pkg::Q_C})
                                                   : CW'(sum_i);
      diff_i     = {1'b0, a_i} + {1'b0, lwr_pkg::Q_C} - {1'b0, b_i};
      diff_mod_i = (diff_i >= {1'b0, lwr_pkg::Q_C}) ? CW'(diff_i - {1'b0, lwr_pkg::Q_C})
                                                    : CW'(diff_i);
      neg_i      = a_i > lwr_pkg::HALF_Q_C;
      mag_i      = neg_i ? lwr_pkg::Q_C - a_i : a_i;

      pa_in.op    = op_i;
      pa_in.opa   = a_i;
      pa_in.neg   = neg_i;
      pa_in.pbits = pbits_i;
      pa_in.mbits = mbits_i;

      case (op_i)
         lwr_pkg::OP_ADD, lwr_pkg::OP_SUB, lwr_pkg::OP_QUANT: pa_in.err = a_ge_q || b_ge_q;
         lwr_pkg::OP_DEQUANT: pa_in.err = (a_i >> pbits_i) != '0;
         lwr_pkg::OP_ENCODE:  pa_in.err = (a_i >> mbits_i) != '0;
         lwr_pkg::OP_DECODE:  pa_in.err = a_ge_q;
         default:             pa_in.err = 1'b1;
      endcase

      case (op_i)
         lwr_pkg::OP_SUB:    pa_in.early = diff_mod_i;
         lwr_pkg::OP_DECODE: pa_in.early = mag_i;
         default:            pa_in.early = sum_mod_i;
      endcase
   end

   // stage B: dividend for quantize and decode, dequantize and encode products
   always_comb begin
      case (pa_ff.op)
         lwr_pkg::OP_QUANT:  y_b_in = lwr_pkg::Y_W'(pa_ff.early) << pa_ff.pbits;
         lwr_pkg::OP_DECODE: y_b_in = (lwr_pkg::Y_W'(pa_ff.early) << (pa_ff.mbits + 3'd1))
                                      + lwr_pkg::Y_W'(lwr_pkg::MODULUS);
         default:            y_b_in = '0;
      endcase

      dq_prod = lwr_pkg::DQ_W'(pa_ff.opa) * lwr_pkg::DQ_W'(lwr_pkg::MODULUS)
                + ((lwr_pkg::DQ_W'(1) << pa_ff.pbits) >> 1);
      deq_b   = CW'(dq_prod >> pa_ff.pbits);
      enc_b   = CW'(lwr_pkg::DQ_W'(pa_ff.opa) * (lwr_pkg::DQ_W'(lwr_pkg::Q_C) >> pa_ff.mbits));

      pb_in = pa_ff;
      case (pa_ff.op)
         lwr_pkg::OP_DEQUANT: pb_in.early = deq_b;
         lwr_pkg::OP_ENCODE:  pb_in.early = enc_b;
         default:             pb_in.early = pa_ff.early;
      endcase
   end

   // stage C: wrap a dequantized value that rounded up to Q
   always_comb begin
      pc_in = pb_ff;
      if (pb_ff.op == lwr_pkg::OP_DEQUANT && pb_ff.early >= lwr_pkg::Q_C) begin
         pc_in.early = pb_ff.early - lwr_pkg::Q_C;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) pa_ff <= pa_in;
      if (rdy_b) begin
         pb_ff  <= pb_in;
         y_b_ff <= y_b_in;
      end
      if (rdy_c) pc_ff <= pc_in;
      if (rdy_d) pd_ff <= pc_ff;
   end

   assign div_ctrl.load_c = rdy_c;
   assign div_ctrl.load_d = rdy_d;

   lwr_divq u_divq (
      .clock (clock),
      .ctrl  (div_ctrl),
      .y     (y_b_ff),
      .quo   (quo)
   );

   // stage E: final selection
   always_comb begin
      pmask = ~({CW{1'b1}} << pd_ff.pbits);
      mmask = ~({CW{1'b1}} << pd_ff.mbits);
      t_e   = (CW'(quo) >> 1) & mmask;
      if (pd_ff.err) begin
         rsp_data_in = '0;
      end else begin
         case (pd_ff.op)
            lwr_pkg::OP_QUANT:  rsp_data_in = CW'(quo) & pmask;
            lwr_pkg::OP_DECODE: rsp_data_in = (pd_ff.neg && t_e != '0) ? (CW'(0) - t_e) & mmask
                                                                      : t_e;
            default:            rsp_data_in = pd_ff.early;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_e) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= pd_ff.err;
      end
   end

endmodule
